### rtl/xbrsq_pkg.sv
// xbrsq_pkg: shared widths, item codes and handshake structs for the XOR span query block.
// No dependencies; used by every module under rtl.
package xbrsq_pkg;

   localparam int VALUE_BITS = 30;
   localparam int INDEX_BITS = 12;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef logic [VALUE_BITS-1:0] word_type;

   // word stream into the basis unit
   typedef struct packed {
      logic valid;
      logic last;    // the test word, reduced but never inserted
   } feed_type;

   typedef struct packed {
      logic done;
      logic representable;
   } result_type;

endpackage

### rtl/xor_basis_range_span_query.sv
// xor_basis_range_span_query: top level, command sequencer around the word store and basis unit.
// Depends on xbrsq_pkg, xbrsq_store, xbrsq_basis.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------------------
//  request  | start / busy          | req_kind, req_load_index, req_load_value,
//           |                       | req_range_start, req_range_end, req_query_value
//  response | rsp_strobe (1 cycle)  | rsp_representable
//
//  A load leaves busy low. A query holds busy while it reads the in-store words of its range,
//  one store read per word, then passes the test word through the two basis stages
//  and the result register.
//  rsp_strobe is high in the last busy cycle; a new item may start in the next cycle.
//  After reset the store is cleared one word per cycle, with busy high.
//  The receiver cannot stall; the strobe is never held.
module xor_basis_range_span_query #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [xbrsq_pkg::INDEX_BITS-1:0]    req_load_index,
   input  logic [xbrsq_pkg::VALUE_BITS-1:0]    req_load_value,
   input  logic [xbrsq_pkg::INDEX_BITS-1:0]    req_range_start,
   input  logic [xbrsq_pkg::INDEX_BITS-1:0]    req_range_end,
   input  logic [xbrsq_pkg::VALUE_BITS-1:0]    req_query_value,
   output logic                                rsp_strobe,
   output logic                                rsp_representable
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = ((AW > xbrsq_pkg::INDEX_BITS) ? AW : xbrsq_pkg::INDEX_BITS) + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
   localparam logic [CW-1:0] LAST_C  = CW'(STORE_DEPTH - 1);
   localparam logic [AW-1:0] LAST_A  = AW'(STORE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_QWORD,
      ST_WAIT
   } state_type;

   state_type             state_ff, state_in;
   logic                  busy_ff;
   logic [AW-1:0]         clr_ff;
   logic [CW-1:0]         cur_ff;
   logic [CW-1:0]         end_ff;
   xbrsq_pkg::word_type   q_ff;
   logic                  rvalid_ff;
   logic                  qsel_ff;

   logic                  accept;
   logic                  load_go;
   logic                  query_go;
   logic [CW-1:0]         lo_ext;
   logic [CW-1:0]         hi_ext;
   logic [CW-1:0]         hi_clamp;
   logic [CW-1:0]         load_ext;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   xbrsq_pkg::word_type   wr_data;
   xbrsq_pkg::word_type   rd_data;

   xbrsq_pkg::feed_type   feed;
   xbrsq_pkg::word_type   feed_word;
   xbrsq_pkg::result_type result;

   assign accept   = start & ~busy_ff;
   assign load_go  = accept & (req_kind == xbrsq_pkg::KIND_LOAD) & (load_ext < DEPTH_C);
   assign query_go = accept & (req_kind == xbrsq_pkg::KIND_QUERY);
   assign lo_ext   = CW'(req_range_start);
   assign hi_ext   = CW'(req_range_end);
   assign hi_clamp = (hi_ext > LAST_C) ? LAST_C : hi_ext;
   assign load_ext = CW'(req_load_index);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_A) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (query_go) begin
               state_in = (lo_ext <= hi_clamp) ? ST_SCAN : ST_QWORD;
            end
         end
         ST_SCAN: begin
            if (cur_ff == end_ff) begin
               state_in = ST_QWORD;
            end
         end
         ST_QWORD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (result.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (query_go) begin
         cur_ff <= lo_ext;
         end_ff <= hi_clamp;
         q_ff   <= req_query_value;
      end else if (state_ff == ST_SCAN) begin
         cur_ff <= cur_ff + CW'(1);
      end
      if (reset) begin
         state_ff  <= ST_CLEAR;
         busy_ff   <= 1'b1;
         clr_ff    <= '0;
         rvalid_ff <= 1'b0;
         qsel_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != ST_IDLE);
         rvalid_ff <= (state_ff == ST_SCAN);
         qsel_ff   <= (state_ff == ST_QWORD);
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = load_go;
         wr_addr = load_ext[AW-1:0];
         wr_data = req_load_value;
      end
   end

   xbrsq_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign feed.valid = rvalid_ff | qsel_ff;
   assign feed.last  = qsel_ff;
   assign feed_word  = qsel_ff ? q_ff : rd_data;

   xbrsq_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .clear     (query_go),
      .feed      (feed),
      .feed_word (feed_word),
      .result    (result)
   );

   assign busy              = busy_ff;
   assign rsp_strobe        = result.done;
   assign rsp_representable = result.representable;

endmodule

### rtl/xbrsq_store.sv
// xbrsq_store: word store, one write port and one read port with registered read data.
// Depends on xbrsq_pkg.
module xbrsq_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  xbrsq_pkg::word_type   wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output xbrsq_pkg::word_type   rd_data
);

   xbrsq_pkg::word_type store_ff [DEPTH];
   xbrsq_pkg::word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/xbrsq_basis.sv
// xbrsq_basis: fully reduced GF(2) basis, one word per cycle in two stages (reduce, insert).
// Depends on xbrsq_pkg.
module xbrsq_basis (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  xbrsq_pkg::feed_type     feed,
   input  xbrsq_pkg::word_type     feed_word,
   output xbrsq_pkg::result_type   result
);

   localparam int VB = xbrsq_pkg::VALUE_BITS;

   // basis_ff[b] is zero or has its leading one at bit b and zeros at all other pivots
   xbrsq_pkg::word_type   basis_ff [VB];
   xbrsq_pkg::word_type   basis_in [VB];

   xbrsq_pkg::word_type   red_in;
   xbrsq_pkg::word_type   r_ff;
   xbrsq_pkg::feed_type   rfeed_ff;

   xbrsq_pkg::word_type   last_r_ff;
   xbrsq_pkg::word_type   last_lead_ff;
   logic                  last_ok_ff;

   xbrsq_pkg::word_type   corr;
   xbrsq_pkg::word_type   lead;
   logic                  insert;

   xbrsq_pkg::result_type result_ff;
   xbrsq_pkg::result_type result_in;

   // reduce stage: clear every pivot bit of the incoming word
   always_comb begin
      red_in = feed_word;
      for (int b = 0; b < VB; b++) begin
         if (feed_word[b]) begin
            red_in = red_in ^ basis_ff[b];
         end
      end
   end

   // insert stage: fold in the word inserted in the previous cycle, which the reduce stage missed
   always_comb begin
      corr = r_ff;
      if (last_ok_ff && |(r_ff & last_lead_ff)) begin
         corr = r_ff ^ last_r_ff;
      end
      for (int j = 0; j < VB; j++) begin
         lead[j] = corr[j] & ~|(corr >> (j + 1));
      end
      insert = rfeed_ff.valid & ~rfeed_ff.last & (|corr);
      for (int b = 0; b < VB; b++) begin
         if (clear) begin
            basis_in[b] = '0;
         end else if (insert && lead[b]) begin
            basis_in[b] = corr;
         end else if (insert && |(basis_ff[b] & lead)) begin
            basis_in[b] = basis_ff[b] ^ corr;
         end else begin
            basis_in[b] = basis_ff[b];
         end
      end
      result_in.done          = rfeed_ff.valid & rfeed_ff.last;
      result_in.representable = (corr == '0);
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < VB; b++) begin
         basis_ff[b] <= basis_in[b];
      end
      r_ff         <= red_in;
      last_r_ff    <= corr;
      last_lead_ff <= lead;
      if (reset) begin
         rfeed_ff   <= '0;
         last_ok_ff <= 1'b0;
         result_ff  <= '0;
      end else begin
         rfeed_ff   <= feed;
         last_ok_ff <= insert & ~clear;
         result_ff  <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### rtl/xbrsq_checker.sv
// xbrsq_checker: port-level checks on the span query top level, and its bind.
// Depends on xbrsq_pkg and xor_basis_range_span_query.
module xbrsq_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_kind,
   input logic rsp_strobe
);

   // reset starts the store clearing pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == xbrsq_pkg::KIND_LOAD) |=> !busy)
      else $error("load item raised busy");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == xbrsq_pkg::KIND_QUERY) |=> busy)
      else $error("query item did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("busy still high after result strobe");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in a row");

endmodule

bind xor_basis_range_span_query xbrsq_checker u_xbrsq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_kind   (req_kind),
   .rsp_strobe (rsp_strobe)
);

### dv/xbrsq_span_checker.sv
// xbrsq_span_checker: watches the request and response channels of xor_basis_range_span_query.
// It keeps its own word store, predicts each query answer and compares it with the response.
// Depends on xbrsq_pkg.
module xbrsq_span_checker
   import xbrsq_pkg::*;
#(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_kind,
   input  logic [INDEX_BITS-1:0] req_load_index,
   input  word_type              req_load_value,
   input  logic [INDEX_BITS-1:0] req_range_start,
   input  logic [INDEX_BITS-1:0] req_range_end,
   input  word_type              req_query_value,
   input  logic                  rsp_strobe,
   input  logic                  rsp_representable,
   output int                    failures,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   word_type word_store [STORE_DEPTH];
   logic     answers_due [$];

   // reduce every word of the range from the top bit down, then the probe word
   function automatic logic span_holds(input logic [INDEX_BITS-1:0] lo,
                                       input logic [INDEX_BITS-1:0] hi,
                                       input word_type probe);
      word_type basis [VALUE_BITS];
      word_type w;
      int       top;
      int       count;
      logic     fresh;
      top = (int'(hi) < STORE_DEPTH) ? int'(hi) : STORE_DEPTH - 1;
      count = (int'(lo) <= top) ? top - int'(lo) + 1 : 0;
      foreach (basis[b]) basis[b] = '0;
      fresh = 1'b0;
      for (int k = 0; k <= count; k++) begin
         w = (k < count) ? word_store[int'(lo) + k] : probe;
         fresh = 1'b0;
         for (int b = VALUE_BITS - 1; b >= 0; b--) begin
            if (w[b] && !fresh) begin
               if (basis[b] == '0) begin
                  basis[b] = w;
                  fresh = 1'b1;
               end else begin
                  w ^= basis[b];
               end
            end
         end
      end
      return !fresh;
   endfunction

   always @(posedge clock) begin
      logic expected;
      if (reset) begin
         foreach (word_store[i]) word_store[i] = '0;
         answers_due.delete();
         failures <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               $error("rsp_representable: expected no response, got %0b", rsp_representable);
               failures <= failures + 1;
            end else begin
               expected = answers_due.pop_front();
               if (rsp_representable !== expected) begin
                  $error("rsp_representable: expected %0b, got %0b",
                         expected, rsp_representable);
                  failures <= failures + 1;
               end
            end
         end
         if (start && !busy) begin
            if (req_kind == KIND_LOAD) begin
               if (int'(req_load_index) < STORE_DEPTH)
                  word_store[req_load_index] = req_load_value;
            end else
               answers_due.push_back(span_holds(req_range_start, req_range_end,
                                                req_query_value));
         end
         outstanding <= answers_due.size();
      end
   end

endmodule

### dv/tb_xor_basis_range_span_query.sv
// tb_xor_basis_range_span_query: drives loads and span queries into the block and gives the verdict.
// Depends on xbrsq_pkg, xor_basis_range_span_query and xbrsq_span_checker.
module tb_xor_basis_range_span_query;
   timeunit 1ns;
   timeprecision 1ps;
   import xbrsq_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_ITEMS = 40;
   localparam word_type ALL_ONES = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = KIND_LOAD;
   logic [INDEX_BITS-1:0] req_load_index = '0;
   word_type              req_load_value = '0;
   logic [INDEX_BITS-1:0] req_range_start = '0;
   logic [INDEX_BITS-1:0] req_range_end = '0;
   word_type              req_query_value = '0;
   logic                  rsp_strobe;
   logic                  rsp_representable;
   int                    failures;
   int                    outstanding;

   word_type loaded_words [STORE_DEPTH];
   int       idle_pct = 14;
   int       items_sent = 0;
   int       stalled_cycles = 0;

   always #2 clock = ~clock;

   xor_basis_range_span_query #(.STORE_DEPTH(STORE_DEPTH)) dut (.*);

   xbrsq_span_checker #(.STORE_DEPTH(STORE_DEPTH)) span_checker (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   task automatic pause_sender();
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic hand_over();
      start <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic issue_load(input int idx, input word_type val);
      pause_sender();
      req_kind <= KIND_LOAD;
      req_load_index <= idx[INDEX_BITS-1:0];
      req_load_value <= val;
      req_range_start <= INDEX_BITS'($urandom);
      req_range_end <= INDEX_BITS'($urandom);
      req_query_value <= word_type'($urandom);
      hand_over();
      loaded_words[idx] = val;
   endtask

   task automatic issue_query(input int lo, input int hi, input word_type q);
      pause_sender();
      req_kind <= KIND_QUERY;
      req_load_index <= INDEX_BITS'($urandom);
      req_load_value <= word_type'($urandom);
      req_range_start <= lo[INDEX_BITS-1:0];
      req_range_end <= hi[INDEX_BITS-1:0];
      req_query_value <= q;
      hand_over();
   endtask

   task automatic drain_answers();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // probe words: subset XORs of the range, zero, near misses and noise
   task automatic random_query(input int base, input int len);
      int       lo;
      int       hi;
      int       swap;
      int       pick;
      word_type q;
      lo = base + $urandom_range(len - 1);
      hi = base + $urandom_range(len - 1);
      if (lo > hi && $urandom_range(9) != 0) begin
         swap = lo;
         lo = hi;
         hi = swap;
      end
      pick = $urandom_range(99);
      q = '0;
      if (pick < 45) begin
         for (int i = lo; i <= hi; i++)
            if ($urandom_range(1) != 0) q ^= loaded_words[i];
      end else if (pick < 60) begin
         q = '0;
      end else if (pick < 75) begin
         q = loaded_words[hi] ^ (word_type'(1) << $urandom_range(VALUE_BITS - 1));
      end else begin
         q = word_type'($urandom);
      end
      issue_query(lo, hi, q);
   endtask

   initial begin
      int       len;
      int       base;
      int       style;
      int       phase_end;
      int       random_end;
      word_type val;
      word_type pool [4];
      foreach (loaded_words[i]) loaded_words[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // cleared store, extremes, zero words, empty ranges
      issue_query(0, STORE_DEPTH - 1, '0);
      issue_query(0, STORE_DEPTH - 1, ALL_ONES);
      issue_load(0, ALL_ONES);
      issue_load(STORE_DEPTH - 1, word_type'(1) << (VALUE_BITS - 1));
      issue_load(1, word_type'(1));
      issue_load(2, '0);
      issue_query(0, 0, ALL_ONES);
      issue_query(0, 2, ALL_ONES ^ word_type'(1));
      issue_query(1, 2, word_type'(2));
      issue_query(STORE_DEPTH - 1, STORE_DEPTH - 1, word_type'(1) << (VALUE_BITS - 1));
      issue_query(2, 2, '0);
      issue_query(2, 2, word_type'(1));
      issue_query(5, 3, '0);
      issue_query(STORE_DEPTH - 1, 0, word_type'(1));
      issue_query(0, STORE_DEPTH - 1, ALL_ONES ^ (word_type'(1) << (VALUE_BITS - 1)));
      issue_load(3, word_type'(30'h1555_5555));
      issue_load(4, word_type'(30'h2AAA_AAAA));
      issue_query(3, 4, ALL_ONES);
      issue_query(3, 4, word_type'(30'h1555_5554));

      phase_end = items_sent + PHASE_ITEMS;
      random_end = items_sent + 3 * PHASE_ITEMS;
      while (items_sent < random_end) begin
         if (items_sent >= phase_end && idle_pct != 0) begin
            drain_answers();
            idle_pct = (idle_pct == 14) ? 55 : 0;
            phase_end += PHASE_ITEMS;
         end
         len = ($urandom_range(99) < 4) ? $urandom_range(256, STORE_DEPTH)
                                        : $urandom_range(1, 24);
         base = $urandom_range(STORE_DEPTH - len);
         foreach (pool[p]) pool[p] = word_type'($urandom);
         repeat ($urandom_range(1, 8)) begin
            style = $urandom_range(99);
            val = '0;
            if (style < 40) begin
               foreach (pool[p])
                  if ($urandom_range(1) != 0) val ^= pool[p];
            end else if (style < 65) begin
               val = word_type'($urandom);
            end else if (style >= 80) begin
               val = word_type'(1) << $urandom_range(VALUE_BITS - 1);
            end
            issue_load(base + $urandom_range(len - 1), val);
         end
         repeat ($urandom_range(1, 4)) random_query(base, len);
      end

      drain_answers();
      repeat (16) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
